// ----- rtl/vector_to_ra_dec_angles_top_macros.svh -----
// Assertion macros for the direction-to-angles block.
// Both sample on aclk and are disabled while aresetn is low.
`ifndef VECTOR_TO_RA_DEC_ANGLES_TOP_MACROS_SVH
`define VECTOR_TO_RA_DEC_ANGLES_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define V2RD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("v2rd: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define V2RD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("v2rd: next-cycle check failed");

`endif

// ----- rtl/v2rd_pkg.sv -----
`timescale 1ns / 1ps

package v2rd_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int ANGLE_WIDTH   = 32;
    localparam int CORDIC_STAGES = 32;

    localparam int ATAB_LEN    = 64;
    localparam int IDX_W       = $clog2(ATAB_LEN);
    localparam int N_CELLS     = (CORDIC_STAGES < ATAB_LEN) ? CORDIC_STAGES : ATAB_LEN;
    localparam int DW          = 64;
    localparam int COORD_SHIFT = 60 - COORD_WIDTH;
    localparam int ROUND_SHIFT = 63 - ANGLE_WIDTH;
    localparam int S_TDATA_W   = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((2 * ANGLE_WIDTH + 7) / 8) * 8;

    localparam logic [63:0] INV_PI_Q64   = 64'h517CC1B727220A95;
    localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;

    localparam logic [63:0] Q62_ONE = 64'd1 << 62;

    // Entry k is 2^62 over 2k+1, truncated.
    localparam logic [31:0][63:0] ODD_RECIP = {
        Q62_ONE / 64'd63, Q62_ONE / 64'd61, Q62_ONE / 64'd59, Q62_ONE / 64'd57,
        Q62_ONE / 64'd55, Q62_ONE / 64'd53, Q62_ONE / 64'd51, Q62_ONE / 64'd49,
        Q62_ONE / 64'd47, Q62_ONE / 64'd45, Q62_ONE / 64'd43, Q62_ONE / 64'd41,
        Q62_ONE / 64'd39, Q62_ONE / 64'd37, Q62_ONE / 64'd35, Q62_ONE / 64'd33,
        Q62_ONE / 64'd31, Q62_ONE / 64'd29, Q62_ONE / 64'd27, Q62_ONE / 64'd25,
        Q62_ONE / 64'd23, Q62_ONE / 64'd21, Q62_ONE / 64'd19, Q62_ONE / 64'd17,
        Q62_ONE / 64'd15, Q62_ONE / 64'd13, Q62_ONE / 64'd11, Q62_ONE / 64'd9,
        Q62_ONE / 64'd7,  Q62_ONE / 64'd5,  Q62_ONE / 64'd3,  Q62_ONE / 64'd1
    };

    typedef logic signed [DW-1:0] word_t;

    localparam word_t ANG_PI   = word_t'(64'd1 << 62);
    localparam word_t HALF_PI  = word_t'(64'd1 << (ANGLE_WIDTH - 2));
    localparam word_t ROUND_HALF = word_t'(64'd1 << (ROUND_SHIFT - 1));

    typedef struct packed {
        word_t x;
        word_t y;
        word_t ang;
    } vec_t;

    typedef struct packed {
        logic  zero_vec;
        logic  xy_zero;
        word_t aux;
    } side_t;

    typedef logic [ATAB_LEN-1:0][63:0] atab_t;

    function automatic logic [63:0] mul_hi64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid;
        al  = {32'd0, a[31:0]};
        ah  = {32'd0, a[63:32]};
        bl  = {32'd0, b[31:0]};
        bh  = {32'd0, b[63:32]};
        ll  = al * bl;
        lh  = al * bh;
        hl  = ah * bl;
        hh  = ah * bh;
        mid = (ll >> 32) + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
        return hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
    endfunction

    // Arctangent of 2^-i by its power series, scaled so that pi is 2^62.
    function automatic logic [63:0] atan_entry(input int i);
        logic [63:0] rad, term;
        int          e;
        rad = 64'd0;
        if (i == 0) begin
            return 64'd1 << 60;
        end
        for (int k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 62) begin
                term = ODD_RECIP[k] >> e;
                if (k % 2 == 1) begin
                    rad = rad - term;
                end else begin
                    rad = rad + term;
                end
            end
        end
        return mul_hi64(rad, INV_PI_Q64);
    endfunction

    function automatic atab_t build_atan_table();
        atab_t t;
        for (int i = 0; i < ATAB_LEN; i++) begin
            t[i] = atan_entry(i);
        end
        return t;
    endfunction

    localparam atab_t ATAN_TABLE = build_atan_table();

    function automatic word_t round_angle(input word_t a);
        word_t t;
        t = a + ROUND_HALF;
        return t >>> ROUND_SHIFT;
    endfunction

endpackage

// ----- rtl/vector_to_ra_dec_angles_top.sv -----
`timescale 1ns / 1ps
// Converts a direction vector (x, y, z) into right ascension atan2(y, x) and
// declination atan2(z, |(x, y)|) as binary angles in which 2^(ANGLE_WIDTH-1)
// is pi. One word is accepted per cycle while the output is not stalled. The
// pipeline has one input stage, a row of CORDIC cells for the azimuth pass,
// two stages for the inverse gain multiply, a second row of cells for the
// elevation pass and the output register. Every cell holds one micro-rotation,
// so the rate is one word a cycle; while a result word waits with m_tready
// low the whole pipeline holds. An all-zero vector gives zero angles with
// tuser set.

module vector_to_ra_dec_angles_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // x_coord, y_coord, z_coord
    input  logic [v2rd_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // ra_angle, dec_angle
    output logic [v2rd_pkg::M_TDATA_W-1:0]  m_tdata,
    // zero_vector
    output logic [0:0]                      m_tuser
);
    import v2rd_pkg::*;

    `include "vector_to_ra_dec_angles_top_macros.svh"

    logic advance;

    logic signed [COORD_WIDTH-1:0] x_raw;
    logic signed [COORD_WIDTH-1:0] y_raw;
    logic signed [COORD_WIDTH-1:0] z_raw;
    word_t x_sh;
    word_t y_sh;
    word_t z_sh;
    vec_t  st0_vec_next;
    side_t st0_side_next;

    logic  st0_valid_reg;
    vec_t  st0_vec_reg;
    side_t st0_side_reg;

    logic  c1_valid;
    vec_t  c1_vec;
    side_t c1_side;

    word_t mid_r;
    side_t mid_side;

    logic  g_valid;
    word_t g_r;
    word_t g_z;
    side_t g_side;
    vec_t  c2_in_vec;

    logic  c2_valid;
    vec_t  c2_vec;
    side_t c2_side;

    word_t ra_full;
    word_t dec_full;
    logic [M_TDATA_W-1:0] m_data_next;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_user_reg;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;

    always_comb begin
        x_raw = s_tdata[COORD_WIDTH-1:0];
        y_raw = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
        z_raw = s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
        x_sh  = word_t'(x_raw) <<< COORD_SHIFT;
        y_sh  = word_t'(y_raw) <<< COORD_SHIFT;
        z_sh  = word_t'(z_raw) <<< COORD_SHIFT;

        st0_side_next.zero_vec = (x_raw == '0) && (y_raw == '0) && (z_raw == '0);
        st0_side_next.xy_zero  = (x_raw == '0) && (y_raw == '0);
        st0_side_next.aux      = z_sh;

        // A vector in the left half plane is turned by pi first.
        if (x_sh[DW-1]) begin
            st0_vec_next.x   = -x_sh;
            st0_vec_next.y   = -y_sh;
            st0_vec_next.ang = ANG_PI;
        end else begin
            st0_vec_next.x   = x_sh;
            st0_vec_next.y   = y_sh;
            st0_vec_next.ang = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_valid_reg <= 1'b0;
        end else if (advance) begin
            st0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            st0_vec_reg  <= st0_vec_next;
            st0_side_reg <= st0_side_next;
        end
    end

    v2rd_cordic_chain u_ra_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .in_valid  (st0_valid_reg),
        .in_vec    (st0_vec_reg),
        .in_side   (st0_side_reg),
        .out_valid (c1_valid),
        .out_vec   (c1_vec),
        .out_side  (c1_side)
    );

    // With x and y both zero the azimuth pass is void: length and angle are zero.
    always_comb begin
        mid_side.zero_vec = c1_side.zero_vec;
        mid_side.xy_zero  = c1_side.xy_zero;
        if (c1_side.xy_zero) begin
            mid_r        = '0;
            mid_side.aux = '0;
        end else begin
            mid_r        = c1_vec.x;
            mid_side.aux = c1_vec.ang;
        end
    end

    v2rd_gain_mult u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .in_valid  (c1_valid),
        .in_r      (mid_r),
        .in_z      (c1_side.aux),
        .in_side   (mid_side),
        .out_valid (g_valid),
        .out_r     (g_r),
        .out_z     (g_z),
        .out_side  (g_side)
    );

    always_comb begin
        c2_in_vec.x   = g_r;
        c2_in_vec.y   = g_z;
        c2_in_vec.ang = '0;
    end

    v2rd_cordic_chain u_dec_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .in_valid  (g_valid),
        .in_vec    (c2_in_vec),
        .in_side   (g_side),
        .out_valid (c2_valid),
        .out_vec   (c2_vec),
        .out_side  (c2_side)
    );

    always_comb begin
        ra_full  = round_angle(c2_side.aux);
        dec_full = round_angle(c2_vec.ang);
        if (dec_full > HALF_PI) begin
            dec_full = HALF_PI;
        end else if (dec_full < -HALF_PI) begin
            dec_full = -HALF_PI;
        end
        m_data_next = '0;
        if (!c2_side.zero_vec) begin
            m_data_next[ANGLE_WIDTH-1:0]             = ra_full[ANGLE_WIDTH-1:0];
            m_data_next[2*ANGLE_WIDTH-1:ANGLE_WIDTH] = dec_full[ANGLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= c2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
            m_user_reg <= c2_side.zero_vec;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    `V2RD_ASSERT_NEXT(a_accept_loads_input_stage, s_tvalid && s_tready, st0_valid_reg)
    `V2RD_ASSERT_SAME(a_folded_x_nonneg, st0_valid_reg, !st0_vec_reg.x[DW-1])
    `V2RD_ASSERT_SAME(a_length_nonneg, c1_valid && !c1_side.xy_zero, !c1_vec.x[DW-1])
    `V2RD_ASSERT_SAME(a_zero_vector_gives_zero, m_tvalid && m_tuser[0], m_tdata == '0)

endmodule

// ----- rtl/v2rd_cordic_cell.sv -----
`timescale 1ns / 1ps

module v2rd_cordic_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic [v2rd_pkg::IDX_W-1:0] idx,
    input  logic               in_valid,
    input  v2rd_pkg::vec_t     in_vec,
    input  v2rd_pkg::side_t    in_side,
    output logic               out_valid,
    output v2rd_pkg::vec_t     out_vec,
    output v2rd_pkg::side_t    out_side
);
    import v2rd_pkg::*;

    logic  valid_reg;
    vec_t  vec_reg;
    vec_t  vec_next;
    side_t side_reg;
    word_t xs;
    word_t ys;
    word_t step_ang;

    always_comb begin
        xs       = in_vec.x >>> idx;
        ys       = in_vec.y >>> idx;
        step_ang = word_t'(ATAN_TABLE[idx]);
        if (!in_vec.y[DW-1]) begin
            vec_next.x   = in_vec.x + ys;
            vec_next.y   = in_vec.y - xs;
            vec_next.ang = in_vec.ang + step_ang;
        end else begin
            vec_next.x   = in_vec.x - ys;
            vec_next.y   = in_vec.y + xs;
            vec_next.ang = in_vec.ang - step_ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

// ----- rtl/v2rd_cordic_chain.sv -----
`timescale 1ns / 1ps

module v2rd_cordic_chain (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  v2rd_pkg::vec_t  in_vec,
    input  v2rd_pkg::side_t in_side,
    output logic            out_valid,
    output v2rd_pkg::vec_t  out_vec,
    output v2rd_pkg::side_t out_side
);
    import v2rd_pkg::*;

    logic [N_CELLS:0] link_valid;
    vec_t             link_vec  [N_CELLS+1];
    side_t            link_side [N_CELLS+1];

    assign link_valid[0] = in_valid;
    assign link_vec[0]   = in_vec;
    assign link_side[0]  = in_side;

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        v2rd_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .idx       (IDX_W'(g)),
            .in_valid  (link_valid[g]),
            .in_vec    (link_vec[g]),
            .in_side   (link_side[g]),
            .out_valid (link_valid[g+1]),
            .out_vec   (link_vec[g+1]),
            .out_side  (link_side[g+1])
        );
    end

    assign out_valid = link_valid[N_CELLS];
    assign out_vec   = link_vec[N_CELLS];
    assign out_side  = link_side[N_CELLS];

endmodule

// ----- rtl/v2rd_gain_mult.sv -----
`timescale 1ns / 1ps

module v2rd_gain_mult (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  v2rd_pkg::word_t in_r,
    input  v2rd_pkg::word_t in_z,
    input  v2rd_pkg::side_t in_side,
    output logic            out_valid,
    output v2rd_pkg::word_t out_r,
    output v2rd_pkg::word_t out_z,
    output v2rd_pkg::side_t out_side
);
    import v2rd_pkg::*;

    logic        s1_valid_reg;
    logic [63:0] s1_lo_prod_reg;
    logic [31:0] s1_hi_reg;
    word_t       s1_z_reg;
    side_t       s1_side_reg;
    logic [63:0] lo_prod_next;
    logic [63:0] hi_prod;

    logic        s2_valid_reg;
    word_t       s2_r_reg;
    word_t       s2_r_next;
    word_t       s2_z_reg;
    side_t       s2_side_reg;

    // Length times the inverse gain, split into two 32 by 32 products.
    always_comb begin
        lo_prod_next = {32'd0, in_r[31:0]} * {32'd0, INV_GAIN_Q32};
        hi_prod      = {32'd0, s1_hi_reg} * {32'd0, INV_GAIN_Q32};
        s2_r_next    = word_t'(hi_prod + (s1_lo_prod_reg >> 32));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_lo_prod_reg <= lo_prod_next;
            s1_hi_reg      <= in_r[63:32];
            s1_z_reg       <= in_z;
            s1_side_reg    <= in_side;
            s2_r_reg       <= s2_r_next;
            s2_z_reg       <= s1_z_reg;
            s2_side_reg    <= s1_side_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_r     = s2_r_reg;
    assign out_z     = s2_z_reg;
    assign out_side  = s2_side_reg;

endmodule

// ----- tb/vector_to_ra_dec_angles_top_tb.sv -----
`timescale 1ns / 1ps

module vector_to_ra_dec_angles_top_tb;

    import v2rd_pkg::*;

    localparam int CW          = v2rd_pkg::COORD_WIDTH;
    localparam int AW          = v2rd_pkg::ANGLE_WIDTH;
    localparam int STAGES      = (v2rd_pkg::CORDIC_STAGES < 64) ? v2rd_pkg::CORDIC_STAGES : 64;
    localparam int LATENCY     = 2 * v2rd_pkg::CORDIC_STAGES + 4;
    localparam int N_RANDOM    = 750;
    localparam logic [63:0] PI_RECIP_Q64   = 64'h517CC1B727220A95;
    localparam logic [63:0] GAIN_RECIP_Q32 = 64'h00000000_9B74EDA8;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } coords_t;

    typedef struct packed {
        logic signed [AW-1:0] ra;
        logic signed [AW-1:0] dec;
        logic                 zero_vec;
    } angles_t;

    class angle_scoreboard;
        logic [63:0] atan_lut [STAGES];
        angles_t     pending_angles [$];
        int          mismatches;

        function new();
            logic [63:0]  rad;
            logic [63:0]  term;
            logic [127:0] prod;
            mismatches = 0;
            atan_lut[0] = 64'd1 << 60;
            for (int i = 1; i < STAGES; i++) begin
                rad = 64'd0;
                for (int k = 0; k < 32; k++) begin
                    if (i * (2 * k + 1) <= 62) begin
                        term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
                        rad = (k % 2 == 1) ? rad - term : rad + term;
                    end
                end
                prod = {64'd0, rad} * {64'd0, PI_RECIP_Q64};
                atan_lut[i] = prod[127:64];
            end
        endfunction

        // Drives the vector onto the positive x axis, accumulating the angle turned.
        function void cordic_vector(inout logic signed [63:0] vx, inout logic signed [63:0] vy,
                                    inout logic [63:0] ang);
            logic signed [63:0] sx;
            logic signed [63:0] sy;
            for (int i = 0; i < STAGES; i++) begin
                sx = vx >>> i;
                sy = vy >>> i;
                if (vy >= 0) begin
                    vx = vx + sy;
                    vy = vy - sx;
                    ang = ang + atan_lut[i];
                end else begin
                    vx = vx - sy;
                    vy = vy + sx;
                    ang = ang - atan_lut[i];
                end
            end
        endfunction

        function logic signed [63:0] to_binary_angle(logic [63:0] acc);
            logic signed [63:0] t;
            t = $signed(acc + (64'd1 << (62 - AW)));
            return t >>> (63 - AW);
        endfunction

        function angles_t predict_angles(coords_t c);
            angles_t            res;
            logic signed [63:0] x;
            logic signed [63:0] y;
            logic signed [63:0] z;
            logic signed [63:0] len;
            logic signed [63:0] dec;
            logic signed [63:0] hp;
            logic [63:0]        ra_acc;
            logic [63:0]        dec_acc;
            logic [63:0]        hi;
            logic [63:0]        lo;
            res = '0;
            if (c.x == 0 && c.y == 0 && c.z == 0) begin
                res.zero_vec = 1'b1;
                return res;
            end
            x = 64'(c.x);
            y = 64'(c.y);
            z = 64'(c.z);
            x = x <<< (60 - CW);
            y = y <<< (60 - CW);
            z = z <<< (60 - CW);
            ra_acc = 64'd0;
            len = 64'sd0;
            if (!(x == 0 && y == 0)) begin
                if (x < 0) begin
                    x = -x;
                    y = -y;
                    ra_acc = 64'd1 << 62;
                end
                cordic_vector(x, y, ra_acc);
                len = x;
            end
            hi = $unsigned(len) >> 32;
            lo = $unsigned(len) & 64'hFFFF_FFFF;
            len = $signed(hi * GAIN_RECIP_Q32 + ((lo * GAIN_RECIP_Q32) >> 32));
            dec_acc = 64'd0;
            cordic_vector(len, z, dec_acc);
            dec = to_binary_angle(dec_acc);
            hp = 64'sd1 <<< (AW - 2);
            if (dec > hp) begin
                dec = hp;
            end else if (dec < -hp) begin
                dec = -hp;
            end
            res.ra  = AW'(to_binary_angle(ra_acc));
            res.dec = AW'(dec);
            return res;
        endfunction

        function void note_vector(coords_t c);
            pending_angles.push_back(predict_angles(c));
        endfunction

        function void check_word(logic [v2rd_pkg::M_TDATA_W-1:0] tdata, logic [0:0] tuser);
            angles_t exp_a;
            angles_t got;
            got.ra       = tdata[AW-1:0];
            got.dec      = tdata[2*AW-1:AW];
            got.zero_vec = tuser[0];
            if (pending_angles.size() == 0) begin
                $error("unexpected result word: ra_angle %0d dec_angle %0d zero_vector %0d",
                       got.ra, got.dec, got.zero_vec);
                mismatches++;
                return;
            end
            exp_a = pending_angles.pop_front();
            if (got.ra !== exp_a.ra) begin
                $error("ra_angle: expected %0d, actual %0d", exp_a.ra, got.ra);
                mismatches++;
            end
            if (got.dec !== exp_a.dec) begin
                $error("dec_angle: expected %0d, actual %0d", exp_a.dec, got.dec);
                mismatches++;
            end
            if (got.zero_vec !== exp_a.zero_vec) begin
                $error("zero_vector: expected %0d, actual %0d", exp_a.zero_vec, got.zero_vec);
                mismatches++;
            end
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [v2rd_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [v2rd_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [0:0]                      m_tuser;

    angle_scoreboard sb;
    coords_t         vectors [$];

    vector_to_ra_dec_angles_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic signed [CW-1:0] pick_coord(int mode);
        logic signed [CW-1:0] v;
        int                   sel;
        v = $urandom;
        case (mode)
            0: begin
                v = $urandom;
            end
            1: begin
                v = $signed(CW'($urandom_range(0, 511))) - 256;
            end
            2: begin
                v = ($urandom_range(0, 2) == 0) ? '0 : CW'($urandom);
            end
            default: begin
                sel = $urandom_range(0, 5);
                case (sel)
                    0: v = {1'b0, {(CW-1){1'b1}}};
                    1: v = {1'b1, {(CW-1){1'b0}}};
                    2: v = 1;
                    3: v = -1;
                    4: v = '0;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic coords_t random_vector();
        coords_t c;
        int      mode;
        mode = $urandom_range(0, 9);
        if (mode == 9 && $urandom_range(0, 2) == 0) begin
            c = '0;
        end else begin
            mode = (mode < 5) ? 0 : (mode < 7) ? 1 : (mode < 8) ? 2 : 3;
            c.x = pick_coord(mode);
            c.y = pick_coord(mode);
            c.z = pick_coord(mode);
        end
        return c;
    endfunction

    function automatic coords_t mk(longint x, longint y, longint z);
        coords_t c;
        c.x = CW'(x);
        c.y = CW'(y);
        c.z = CW'(z);
        return c;
    endfunction

    task automatic send_vectors();
        int  gap;
        bit  burst;
        for (int n = 0; n < vectors.size(); n++) begin
            if (n % 64 == 0) begin
                burst = ($urandom_range(0, 3) == 0);
            end
            gap = burst ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {vectors[n].z, vectors[n].y, vectors[n].x};
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            sb.note_vector(vectors[n]);
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic take_results();
        int gap;
        int count;
        bit burst;
        count = 0;
        forever begin
            if (count % 64 == 0) begin
                burst = ($urandom_range(0, 3) == 0);
            end
            gap = burst ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_word(m_tdata, m_tuser);
            count++;
        end
    endtask

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        longint maxv;
        longint minv;
        sb = new();
        maxv = (64'sd1 <<< (CW - 1)) - 1;
        minv = -(64'sd1 <<< (CW - 1));
        vectors.push_back(mk(0, 0, 0));
        vectors.push_back(mk(maxv, 0, 0));
        vectors.push_back(mk(minv, 0, 0));
        vectors.push_back(mk(-1, 0, 0));
        vectors.push_back(mk(0, maxv, 0));
        vectors.push_back(mk(0, minv, 0));
        vectors.push_back(mk(0, 0, maxv));
        vectors.push_back(mk(0, 0, minv));
        vectors.push_back(mk(0, 0, 1));
        vectors.push_back(mk(0, 0, -1));
        vectors.push_back(mk(maxv, maxv, maxv));
        vectors.push_back(mk(minv, minv, minv));
        vectors.push_back(mk(1, 1, 1));
        vectors.push_back(mk(-1, -1, -1));
        vectors.push_back(mk(maxv, minv, 0));
        vectors.push_back(mk(minv, maxv, 0));
        vectors.push_back(mk(0, minv, maxv));
        vectors.push_back(mk(1, 0, minv));
        vectors.push_back(mk(-1, 1, 0));
        vectors.push_back(mk(-1, -1, maxv));
        vectors.push_back(mk(minv, -1, 1));
        vectors.push_back(mk(1, 0, 0));
        vectors.push_back(mk(0, 0, 0));
        for (int n = 0; n < N_RANDOM; n++) begin
            vectors.push_back(random_vector());
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        fork
            take_results();
        join_none
        send_vectors();
        while (sb.pending_angles.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
